// ----- design/hlpi_pkg.sv -----
// hlpi_pkg: shared types, constants and the rounding helper of the
// hough line pair intersection block; depends on nothing else
package hlpi_pkg;

  // result word format
  localparam int unsigned OUT_BITS = 24;
  localparam int unsigned QW       = OUT_BITS + 2;
  localparam logic [OUT_BITS-1:0] OUT_MAX     = {1'b0, {(OUT_BITS-1){1'b1}}};
  localparam logic [OUT_BITS-1:0] OUT_MIN_MAG = {1'b1, {(OUT_BITS-1){1'b0}}};

  // input word format
  localparam int unsigned RHO_W = 17;
  localparam int unsigned THR_W = 15;

  // internal Q30 trig arithmetic
  localparam logic [31:0] PI_Q30   = 32'd3373259426;
  localparam logic [31:0] Q30_ONE  = 32'd1073741824;
  localparam int unsigned XW       = 31;
  localparam int unsigned X2W      = 32;
  localparam int unsigned TSW      = 33;
  localparam int unsigned PW       = 34;
  localparam int unsigned SW       = 36;
  localparam int unsigned RECIP_SH = 34;
  localparam int unsigned TERMS    = 7;
  localparam int unsigned DIVW     = 8;
  localparam int unsigned TRIG_LAT = 3 * TERMS + 3;
  localparam logic [63:0] RECIP_ONE = 64'd1 << RECIP_SH;

  // series divisors of the sine and cosine terms
  localparam logic [DIVW-1:0] SIN_DIV [TERMS] = '{
    8'd6, 8'd20, 8'd42, 8'd72, 8'd110, 8'd156, 8'd210
  };
  localparam logic [DIVW-1:0] COS_DIV [TERMS] = '{
    8'd2, 8'd12, 8'd30, 8'd56, 8'd90, 8'd132, 8'd182
  };

  // running state of one series evaluation
  typedef struct packed {
    logic [X2W-1:0]       x2;
    logic [TSW-1:0]       ts;
    logic [TSW-1:0]       tc;
    logic signed [SW-1:0] sv;
    logic signed [SW-1:0] cv;
    logic                 neg_cos;
  } hlpi_trig_t;

  // sign and overflow of one quotient lane
  typedef struct packed {
    logic neg;
    logic ovf;
  } hlpi_div_flags_t;

  typedef struct packed {
    logic signed [OUT_BITS-1:0] val;
    logic                       clip;
  } hlpi_coord_t;

  // round half away from zero and saturate one coordinate
  function automatic hlpi_coord_t round_sat(input logic [QW-1:0] quo,
                                            input hlpi_div_flags_t fl);
    logic [QW:0]   inc;
    logic [QW-1:0] half;
    logic [QW-1:0] lim;
    logic [QW-1:0] mag;
    hlpi_coord_t   res;
    inc  = {1'b0, quo} + {{QW{1'b0}}, 1'b1};
    half = inc[QW:1];
    lim  = fl.neg ? QW'(OUT_MIN_MAG) : QW'(OUT_MAX);
    res.clip = fl.ovf || (half > lim);
    mag  = res.clip ? lim : half;
    res.val = fl.neg ? -$signed(mag[OUT_BITS-1:0]) : $signed(mag[OUT_BITS-1:0]);
    return res;
  endfunction

endpackage

// ----- design/hough_line_pair_intersection.sv -----
// hough_line_pair_intersection: top level, trig chains, cross products and
// quotient cell chains; depends on hlpi_pkg, hlpi_sincos and hlpi_div_cell
//
// Usage: drive a line pair (rho, theta for each line) with start_i high for
// one cycle; the word is taken at that edge. busy_o stays low, so a new word
// may be given in every cycle. Each word yields one result word on the
// cross_x_o, cross_y_o, lines_parallel_o and clipped_o ports, marked by
// result_valid_o for exactly one cycle, once the word has passed the trig
// chains, cross products, quotient set-up, quotient chains and rounding.
// Throughput is one pair per cycle: the sine and cosine come from a chain of
// seven series cells of three stages each, and each quotient from a chain of
// 26 one-bit restoring cells, all fully pipelined.
// The threshold register is to be written (cfg_we_i, cfg_wdata_i) only while
// no pair is in flight; the block does not enforce this. It resets to 1. Reset
// clears the pipeline valid bits, so no result strobe appears for words in
// flight at reset. The receiver cannot stall: each result is shown in one cycle only.
module hough_line_pair_intersection #(
  parameter int unsigned ANGLE_BITS     = 16,
  parameter int unsigned TRIG_FRAC_BITS = 15
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                start_i,
  output logic                                busy_o,
  input  logic                                cfg_we_i,
  input  logic [hlpi_pkg::THR_W-1:0]          cfg_wdata_i,
  input  logic signed [hlpi_pkg::RHO_W-1:0]   rho_first_i,
  input  logic [ANGLE_BITS-1:0]               theta_first_i,
  input  logic signed [hlpi_pkg::RHO_W-1:0]   rho_second_i,
  input  logic [ANGLE_BITS-1:0]               theta_second_i,
  output logic                                result_valid_o,
  output logic signed [hlpi_pkg::OUT_BITS-1:0] cross_x_o,
  output logic signed [hlpi_pkg::OUT_BITS-1:0] cross_y_o,
  output logic                                lines_parallel_o,
  output logic                                clipped_o
);
  import hlpi_pkg::*;

  localparam int unsigned TW       = TRIG_FRAC_BITS + 2;
  localparam int unsigned CsW      = 2 * TW;
  localparam int unsigned PrW      = TW + RHO_W;
  localparam int unsigned NW       = PrW + 1;
  localparam int unsigned DW       = CsW + 1;
  localparam int unsigned RW       = DW + QW;
  localparam int unsigned ThrShift = 2 * TRIG_FRAC_BITS - 15;

  logic [THR_W-1:0] thr_q;
  logic [TRIG_LAT-1:0] vld_q;
  logic signed [RHO_W-1:0] rho1_q [TRIG_LAT];
  logic signed [RHO_W-1:0] rho2_q [TRIG_LAT];
  logic signed [TW-1:0] s1, c1, s2, c2;

  logic vp_q, vd_q, vo_q, po_q, pd_q;
  logic signed [CsW-1:0] c1s2_q, c2s1_q;
  logic signed [PrW-1:0] s2r1_q, s1r2_q, c1r2_q, c2r1_q;

  logic signed [DW-1:0] den;
  logic signed [NW-1:0] nx, ny;
  logic [DW-1:0] den_mag, thr_w;
  logic [NW-1:0] nx_mag, ny_mag;
  logic [DW-1:0] dmag_q;
  logic [NW-1:0] nxmag_q, nymag_q;
  logic negx_q, negy_q;

  logic [RW-1:0] nx_sh, ny_sh, d_sh;
  logic [RW-1:0] ox_rem_q, oy_rem_q;
  logic [DW-1:0] o_den_q;
  hlpi_div_flags_t ox_flg_q, oy_flg_q;

  logic [RW-1:0] x_rem [QW+1];
  logic [RW-1:0] y_rem [QW+1];
  logic [DW-1:0] x_den [QW+1];
  logic [DW-1:0] y_den [QW+1];
  logic [QW-1:0] x_quo [QW+1];
  logic [QW-1:0] y_quo [QW+1];
  hlpi_div_flags_t x_flg [QW+1];
  hlpi_div_flags_t y_flg [QW+1];
  logic [QW-1:0] vdiv_q, pdiv_q;

  hlpi_coord_t res_x, res_y;
  logic                       rv_q, par_q, clip_q;
  logic signed [OUT_BITS-1:0] cx_q, cy_q;

  assign busy_o = 1'b0;

  // threshold register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q <= THR_W'(1);
    end else if (cfg_we_i) begin
      thr_q <= cfg_wdata_i;
    end
  end

  // valid bits of every stage
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q  <= '0;
      vp_q   <= 1'b0;
      vd_q   <= 1'b0;
      vo_q   <= 1'b0;
      vdiv_q <= '0;
      rv_q   <= 1'b0;
    end else begin
      vld_q  <= {vld_q[TRIG_LAT-2:0], start_i};
      vp_q   <= vld_q[TRIG_LAT-1];
      vd_q   <= vp_q;
      vo_q   <= vd_q;
      vdiv_q <= {vdiv_q[QW-2:0], vo_q};
      rv_q   <= vdiv_q[QW-1];
    end
  end

  // rho delay line alongside the trig chains
  always_ff @(posedge clk_i) begin
    rho1_q[0] <= rho_first_i;
    rho2_q[0] <= rho_second_i;
    for (int i = 1; i < TRIG_LAT; i++) begin
      rho1_q[i] <= rho1_q[i-1];
      rho2_q[i] <= rho2_q[i-1];
    end
  end

  hlpi_sincos #(
    .ANGLE_BITS     (ANGLE_BITS),
    .TRIG_FRAC_BITS (TRIG_FRAC_BITS)
  ) u_trig_first (
    .clk_i   (clk_i),
    .theta_i (theta_first_i),
    .sin_o   (s1),
    .cos_o   (c1)
  );

  hlpi_sincos #(
    .ANGLE_BITS     (ANGLE_BITS),
    .TRIG_FRAC_BITS (TRIG_FRAC_BITS)
  ) u_trig_second (
    .clk_i   (clk_i),
    .theta_i (theta_second_i),
    .sin_o   (s2),
    .cos_o   (c2)
  );

  // cross products
  always_ff @(posedge clk_i) begin
    c1s2_q <= CsW'(c1) * CsW'(s2);
    c2s1_q <= CsW'(c2) * CsW'(s1);
    s2r1_q <= PrW'(s2) * PrW'(rho1_q[TRIG_LAT-1]);
    s1r2_q <= PrW'(s1) * PrW'(rho2_q[TRIG_LAT-1]);
    c1r2_q <= PrW'(c1) * PrW'(rho2_q[TRIG_LAT-1]);
    c2r1_q <= PrW'(c2) * PrW'(rho1_q[TRIG_LAT-1]);
  end

  // denominator, numerators, magnitudes and parallel test
  always_comb begin
    den     = DW'(c1s2_q) - DW'(c2s1_q);
    nx      = NW'(s2r1_q) - NW'(s1r2_q);
    ny      = NW'(c1r2_q) - NW'(c2r1_q);
    den_mag = den[DW-1] ? DW'(-den) : DW'(den);
    nx_mag  = nx[NW-1] ? NW'(-nx) : NW'(nx);
    ny_mag  = ny[NW-1] ? NW'(-ny) : NW'(ny);
    thr_w   = DW'(thr_q) << ThrShift;
  end

  always_ff @(posedge clk_i) begin
    dmag_q  <= den_mag;
    nxmag_q <= nx_mag;
    nymag_q <= ny_mag;
    negx_q  <= nx[NW-1] != den[DW-1];
    negy_q  <= ny[NW-1] != den[DW-1];
    pd_q    <= (den_mag == '0) || (den_mag < thr_w);
  end

  // quotient range check and dividend set-up
  always_comb begin
    nx_sh = RW'(nxmag_q) << (TRIG_FRAC_BITS + 1);
    ny_sh = RW'(nymag_q) << (TRIG_FRAC_BITS + 1);
    d_sh  = RW'(dmag_q) << QW;
  end

  always_ff @(posedge clk_i) begin
    ox_rem_q     <= nx_sh;
    oy_rem_q     <= ny_sh;
    o_den_q      <= dmag_q;
    ox_flg_q.neg <= negx_q;
    ox_flg_q.ovf <= nx_sh >= d_sh;
    oy_flg_q.neg <= negy_q;
    oy_flg_q.ovf <= ny_sh >= d_sh;
    po_q         <= pd_q;
  end

  assign x_rem[0] = ox_rem_q;
  assign y_rem[0] = oy_rem_q;
  assign x_den[0] = o_den_q;
  assign y_den[0] = o_den_q;
  assign x_quo[0] = '0;
  assign y_quo[0] = '0;
  assign x_flg[0] = ox_flg_q;
  assign y_flg[0] = oy_flg_q;

  // parallel flag follows the quotient chains
  always_ff @(posedge clk_i) begin
    pdiv_q <= {pdiv_q[QW-2:0], po_q};
  end

  // quotient cell chains, most significant bit first
  for (genvar j = 0; j < QW; j++) begin : g_div
    hlpi_div_cell #(.BIT(QW - 1 - j), .RW(RW), .DW(DW)) u_x (
      .clk_i   (clk_i),
      .rem_i   (x_rem[j]),
      .den_i   (x_den[j]),
      .quo_i   (x_quo[j]),
      .flags_i (x_flg[j]),
      .rem_o   (x_rem[j+1]),
      .den_o   (x_den[j+1]),
      .quo_o   (x_quo[j+1]),
      .flags_o (x_flg[j+1])
    );
    hlpi_div_cell #(.BIT(QW - 1 - j), .RW(RW), .DW(DW)) u_y (
      .clk_i   (clk_i),
      .rem_i   (y_rem[j]),
      .den_i   (y_den[j]),
      .quo_i   (y_quo[j]),
      .flags_i (y_flg[j]),
      .rem_o   (y_rem[j+1]),
      .den_o   (y_den[j+1]),
      .quo_o   (y_quo[j+1]),
      .flags_o (y_flg[j+1])
    );
  end

  // rounding, saturation and result word
  assign res_x = round_sat(x_quo[QW], x_flg[QW]);
  assign res_y = round_sat(y_quo[QW], y_flg[QW]);

  always_ff @(posedge clk_i) begin
    if (pdiv_q[QW-1]) begin
      cx_q   <= OUT_MAX;
      cy_q   <= OUT_MAX;
      par_q  <= 1'b1;
      clip_q <= 1'b0;
    end else begin
      cx_q   <= res_x.val;
      cy_q   <= res_y.val;
      par_q  <= 1'b0;
      clip_q <= res_x.clip | res_y.clip;
    end
  end

  assign result_valid_o   = rv_q;
  assign cross_x_o        = cx_q;
  assign cross_y_o        = cy_q;
  assign lines_parallel_o = par_q;
  assign clipped_o        = clip_q;

endmodule

// ----- design/hlpi_trig_cell.sv -----
// hlpi_trig_cell: one term of the sine and cosine series, three stages
// depends on hlpi_pkg
module hlpi_trig_cell #(
  parameter int unsigned TERM = 1
) (
  input  logic                clk_i,
  input  hlpi_pkg::hlpi_trig_t trig_i,
  output hlpi_pkg::hlpi_trig_t trig_o
);
  import hlpi_pkg::*;

  localparam logic [DIVW-1:0] SinDiv   = SIN_DIV[TERM-1];
  localparam logic [DIVW-1:0] CosDiv   = COS_DIV[TERM-1];
  localparam logic [PW-1:0]   SinRecip = PW'(RECIP_ONE / 64'(SinDiv));
  localparam logic [PW-1:0]   CosRecip = PW'(RECIP_ONE / 64'(CosDiv));
  localparam bit              Subtract = (TERM % 2) == 1;

  hlpi_trig_t          s1_q, s2_q, s3_q;
  logic [PW-1:0]       ps1_q, pc1_q, ps2_q, pc2_q, qs2_q, qc2_q;
  logic [TSW+X2W-1:0]  prod_s, prod_c;
  logic [2*PW-1:0]     qprod_s, qprod_c;
  logic [PW-1:0]       rem_s, rem_c, qs_fix, qc_fix;
  logic signed [SW-1:0] ts_ext, tc_ext;
  hlpi_trig_t          s3_d;

  // term times x squared
  assign prod_s = (TSW+X2W)'(trig_i.ts) * (TSW+X2W)'(trig_i.x2);
  assign prod_c = (TSW+X2W)'(trig_i.tc) * (TSW+X2W)'(trig_i.x2);

  always_ff @(posedge clk_i) begin
    s1_q  <= trig_i;
    ps1_q <= prod_s[30 +: PW];
    pc1_q <= prod_c[30 +: PW];
  end

  // quotient estimate by reciprocal
  assign qprod_s = (2*PW)'(ps1_q) * (2*PW)'(SinRecip);
  assign qprod_c = (2*PW)'(pc1_q) * (2*PW)'(CosRecip);

  always_ff @(posedge clk_i) begin
    s2_q  <= s1_q;
    ps2_q <= ps1_q;
    pc2_q <= pc1_q;
    qs2_q <= qprod_s[RECIP_SH +: PW];
    qc2_q <= qprod_c[RECIP_SH +: PW];
  end

  // one correction step, then accumulate
  always_comb begin
    rem_s  = ps2_q - qs2_q * PW'(SinDiv);
    rem_c  = pc2_q - qc2_q * PW'(CosDiv);
    qs_fix = (rem_s >= PW'(SinDiv)) ? qs2_q + PW'(1) : qs2_q;
    qc_fix = (rem_c >= PW'(CosDiv)) ? qc2_q + PW'(1) : qc2_q;
    ts_ext = $signed(SW'(qs_fix));
    tc_ext = $signed(SW'(qc_fix));
    s3_d         = s2_q;
    s3_d.ts      = TSW'(qs_fix);
    s3_d.tc      = TSW'(qc_fix);
    s3_d.sv      = Subtract ? s2_q.sv - ts_ext : s2_q.sv + ts_ext;
    s3_d.cv      = Subtract ? s2_q.cv - tc_ext : s2_q.cv + tc_ext;
  end

  always_ff @(posedge clk_i) begin
    s3_q <= s3_d;
  end

  assign trig_o = s3_q;

endmodule

// ----- design/hlpi_sincos.sv -----
// hlpi_sincos: angle fold, series cell chain and rounding to trig format
// depends on hlpi_pkg and hlpi_trig_cell
module hlpi_sincos #(
  parameter int unsigned ANGLE_BITS     = 16,
  parameter int unsigned TRIG_FRAC_BITS = 15
) (
  input  logic                             clk_i,
  input  logic [ANGLE_BITS-1:0]            theta_i,
  output logic signed [TRIG_FRAC_BITS+1:0] sin_o,
  output logic signed [TRIG_FRAC_BITS+1:0] cos_o
);
  import hlpi_pkg::*;

  localparam int unsigned RoundSh = 30 - TRIG_FRAC_BITS;
  localparam logic [ANGLE_BITS-1:0] Half = {1'b1, {(ANGLE_BITS-1){1'b0}}};

  logic                        fold;
  logic [ANGLE_BITS-1:0]       t_f;
  logic [ANGLE_BITS+31:0]      xprod;
  logic [XW-1:0]               x_q;
  logic                        neg_q;
  logic [2*XW-1:0]             x2prod;
  hlpi_trig_t                  init_q;
  hlpi_trig_t                  chain [TERMS+1];
  logic [SW-1:0]               s_pos, c_pos, s_sum, c_sum;
  logic [TRIG_FRAC_BITS:0]     s_mag, c_mag;
  logic signed [TRIG_FRAC_BITS+1:0] sin_q, cos_q;

  // fold into the first quadrant and scale to Q30 radians
  assign fold  = theta_i > Half;
  assign t_f   = fold ? (~theta_i + 1'b1) : theta_i;
  assign xprod = (ANGLE_BITS+32)'(t_f) * (ANGLE_BITS+32)'(PI_Q30);

  always_ff @(posedge clk_i) begin
    x_q   <= xprod[ANGLE_BITS +: XW];
    neg_q <= fold;
  end

  // square and seed the series
  assign x2prod = (2*XW)'(x_q) * (2*XW)'(x_q);

  always_ff @(posedge clk_i) begin
    init_q.x2      <= x2prod[30 +: X2W];
    init_q.ts      <= TSW'(x_q);
    init_q.tc      <= TSW'(Q30_ONE);
    init_q.sv      <= $signed(SW'(x_q));
    init_q.cv      <= $signed(SW'(Q30_ONE));
    init_q.neg_cos <= neg_q;
  end

  assign chain[0] = init_q;

  // one cell per series term
  for (genvar k = 0; k < TERMS; k++) begin : g_term
    hlpi_trig_cell #(.TERM(k + 1)) u_cell (
      .clk_i  (clk_i),
      .trig_i (chain[k]),
      .trig_o (chain[k+1])
    );
  end

  // clamp at zero, round half up, restore cosine sign
  always_comb begin
    s_pos = chain[TERMS].sv[SW-1] ? '0 : chain[TERMS].sv;
    c_pos = chain[TERMS].cv[SW-1] ? '0 : chain[TERMS].cv;
    s_sum = s_pos + (SW'(1) << (RoundSh - 1));
    c_sum = c_pos + (SW'(1) << (RoundSh - 1));
    s_mag = s_sum[RoundSh +: TRIG_FRAC_BITS+1];
    c_mag = c_sum[RoundSh +: TRIG_FRAC_BITS+1];
  end

  always_ff @(posedge clk_i) begin
    sin_q <= $signed({1'b0, s_mag});
    cos_q <= chain[TERMS].neg_cos ? -$signed({1'b0, c_mag}) : $signed({1'b0, c_mag});
  end

  assign sin_o = sin_q;
  assign cos_o = cos_q;

endmodule

// ----- design/hlpi_div_cell.sv -----
// hlpi_div_cell: one restoring division step, one quotient bit per cell
// depends on hlpi_pkg
module hlpi_div_cell #(
  parameter int unsigned BIT = 0,
  parameter int unsigned RW  = 60,
  parameter int unsigned DW  = 35
) (
  input  logic                      clk_i,
  input  logic [RW-1:0]             rem_i,
  input  logic [DW-1:0]             den_i,
  input  logic [hlpi_pkg::QW-1:0]   quo_i,
  input  hlpi_pkg::hlpi_div_flags_t flags_i,
  output logic [RW-1:0]             rem_o,
  output logic [DW-1:0]             den_o,
  output logic [hlpi_pkg::QW-1:0]   quo_o,
  output hlpi_pkg::hlpi_div_flags_t flags_o
);
  import hlpi_pkg::*;

  logic [RW-1:0]   shifted;
  logic            take;
  logic [QW-1:0]   quo_d;
  logic [RW-1:0]   rem_q;
  logic [DW-1:0]   den_q;
  logic [QW-1:0]   quo_q;
  hlpi_div_flags_t flags_q;

  // trial subtract of the shifted divisor
  assign shifted = RW'(den_i) << BIT;
  assign take    = rem_i >= shifted;

  // insert this cell's quotient bit
  always_comb begin
    quo_d      = quo_i;
    quo_d[BIT] = take;
  end

  always_ff @(posedge clk_i) begin
    rem_q   <= take ? rem_i - shifted : rem_i;
    den_q   <= den_i;
    quo_q   <= quo_d;
    flags_q <= flags_i;
  end

  assign rem_o   = rem_q;
  assign den_o   = den_q;
  assign quo_o   = quo_q;
  assign flags_o = flags_q;

endmodule
